// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Entry count, item structs, controller states and command codes.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CAP_W   = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming item
    logic exec;    // look up, update the table, build the result
  } dp_cmd_t;

endpackage

// ----- rtl/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath: entry table, key compare and recency ranks
// Holds the item register, the table and the result register.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkvc_pkg::dp_cmd_t           cmd,
  input  lkvc_pkg::in_item_t          in_item,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
  output lkvc_pkg::out_item_t         out_item
);

  localparam int N  = lkvc_pkg::ENTRIES;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int CW = lkvc_pkg::CNT_W;

  lkvc_pkg::in_item_t  item_r;
  lkvc_pkg::out_item_t res_r;
  logic [N-1:0]        valid_r;
  logic [31:0]         key_r  [N];
  logic [31:0]         data_r [N];
  logic [IW-1:0]       rank_r [N];
  logic [CW-1:0]       count_r;

  logic [N-1:0]  match;
  logic          found;
  logic [IW-1:0] slot;
  logic [IW-1:0] lru;
  logic          any_valid;
  logic [IW-1:0] free_slot;
  logic          has_free;
  logic [CW-1:0] eff_cap;
  logic [IW-1:0] t_slot;
  logic [IW-1:0] t_rank;

  always_comb begin
    found = 1'b0;
    slot = '0;
    lru = '0;
    any_valid = 1'b0;
    has_free = 1'b0;
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (key_r[i] == item_r.key);
      if (match[i]) begin
        found = 1'b1;
        slot = IW'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_slot = IW'(i);
      end
    end
    // Least recent: the one valid slot whose rank is count-1.
    for (int i = 0; i < N; i++) begin
      if (valid_r[i] && ({1'b0, rank_r[i]} == CW'(count_r - 1'b1))) begin
        lru = IW'(i);
        any_valid = 1'b1;
      end
    end
    if (capacity == '0) eff_cap = CW'(1);
    else if (32'(capacity) > N) eff_cap = CW'(N);
    else eff_cap = CW'(capacity);
    t_slot = found ? slot : lru;
    t_rank = rank_r[t_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < N; i++) rank_r[i] <= '0;
    end else if (cmd.exec) begin
      res_r.hit <= found;
      if (item_r.command == lkvc_pkg::CMD_GET)
        res_r.read_value <= found ? data_r[slot] : 32'hFFFF_FFFF;
      else
        res_r.read_value <= '0;
      if (found || (item_r.command == lkvc_pkg::CMD_PUT &&
                    count_r >= eff_cap && any_valid)) begin
        // Touch: age the more recent entries, promote the target.
        for (int i = 0; i < N; i++)
          if (valid_r[i] && IW'(i) != t_slot && rank_r[i] < t_rank)
            rank_r[i] <= rank_r[i] + 1'b1;
        rank_r[t_slot] <= '0;
        if (item_r.command == lkvc_pkg::CMD_PUT) begin
          data_r[t_slot] <= item_r.value;
          key_r[t_slot]  <= item_r.key;
        end
      end else if (item_r.command == lkvc_pkg::CMD_PUT &&
                   count_r < eff_cap && has_free) begin
        for (int i = 0; i < N; i++)
          if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
        rank_r[free_slot]  <= '0;
        valid_r[free_slot] <= 1'b1;
        key_r[free_slot]   <= item_r.key;
        data_r[free_slot]  <= item_r.value;
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign out_item = res_r;

endmodule

// ----- rtl/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl: item sequencer
// Accepts an item, runs one table update, presents the result.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lkvc_pkg::dp_cmd_t        cmd
);

  lkvc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lkvc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkvc_pkg::ST_IDLE: if (in_valid) state_nxt = lkvc_pkg::ST_EXEC;
      lkvc_pkg::ST_EXEC: state_nxt = lkvc_pkg::ST_OUT;
      lkvc_pkg::ST_OUT:  if (!out_stall) state_nxt = lkvc_pkg::ST_IDLE;
      default:           state_nxt = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lkvc_pkg::ST_EXEC: cmd.exec = 1'b1;
      lkvc_pkg::ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Eight entries, parallel key compare, capacity register.
// ----------------------------------------------------------------------------
// channel | handshake             | payload
// in_     | in_valid / in_stall   | in_item  (command, key, value)
// out_    | out_valid / out_stall | out_item (hit, read_value)
// cfg_    | cfg_valid / cfg_ready | cfg_data (capacity)
//
// Each item goes through capture, table update and result in turn. The result
// register holds until the out transfer; no new item enters meanwhile.
// Reset (synchronous, rst_n low) empties the table and sets capacity to 8.
// Capacity writes are always ready.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lkvc_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lkvc_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  logic [lkvc_pkg::CAP_W-1:0] capacity_r;
  lkvc_pkg::dp_cmd_t          cmd;

  assign cfg_ready = 1'b1;

  // Hold the capacity register; update on every cfg transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= lkvc_pkg::CAP_RESET;
    else if (cfg_valid) capacity_r <= cfg_data;
  end

  lkvc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  lkvc_datapath u_dp (
    .clk, .rst_n, .cmd, .in_item, .capacity(capacity_r), .out_item
  );

endmodule

// ----- tb/lru_key_value_cache_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Drives get/put items from a queue, predicts every hit flag and read value
// with a behavioral LRU table, and compares each out transfer in order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lkvc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lkvc_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_key_value_cache u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow of the cache contents
  logic [lkvc_pkg::CAP_W-1:0] shadow_cap;
  logic             slot_live [lkvc_pkg::ENTRIES];
  logic [31:0]      slot_key  [lkvc_pkg::ENTRIES];
  logic [31:0]      slot_data [lkvc_pkg::ENTRIES];
  int unsigned      slot_age  [lkvc_pkg::ENTRIES];
  int unsigned      live_slots;

  lkvc_pkg::in_item_t  pending_items[$];
  lkvc_pkg::out_item_t expected_results[$];
  int        failures = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;
  logic      hold_go = 1'b0;
  logic      hold_done = 1'b0;
  logic      in_taken = 1'b0;
  logic [31:0] key_pool [6];

  // Move slot s to the front of the recency order.
  function automatic void promote(int s);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic lkvc_pkg::out_item_t lookup_and_update(lkvc_pkg::in_item_t it);
    lkvc_pkg::out_item_t r;
    int slot;
    int victim;
    int unsigned eff;
    slot = -1;
    victim = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot == -1 && slot_live[i] && slot_key[i] == it.key) slot = i;
    r.hit = (slot != -1);
    if (it.command == lkvc_pkg::CMD_GET) begin
      if (slot != -1) begin
        r.read_value = slot_data[slot];
        promote(slot);
      end else begin
        r.read_value = -32'sd1;
      end
      return r;
    end
    r.read_value = '0;
    if (slot != -1) begin
      slot_data[slot] = it.value;
      promote(slot);
      return r;
    end
    eff = (shadow_cap < 1) ? 1 :
          (shadow_cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : shadow_cap;
    if (live_slots >= eff) begin
      // evict the least recent live entry
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (slot_live[i] && (victim == -1 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim != -1) begin
        slot_key[victim] = it.key;
        slot_data[victim] = it.value;
        promote(victim);
      end
      return r;
    end
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (victim == -1 && !slot_live[i]) victim = i;
    if (victim != -1) begin
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) if (slot_live[j]) slot_age[j]++;
      slot_live[victim] = 1'b1;
      slot_key[victim] = it.key;
      slot_data[victim] = it.value;
      slot_age[victim] = 0;
      live_slots++;
    end
    return r;
  endfunction

  // Note whether the item on the bus went through at this edge.
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // Driver: offer the head of the queue; hold an item until it transfers.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold
      end else if (pending_items.size() > 0 &&
                   ($urandom_range(99) >= send_idle_pct)) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= (hold_cycles > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Long receiver hold-off, counted in its own process
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cycles <= 200;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: predict on every in transfer, check on every out transfer.
  always @(posedge clk) begin
    lkvc_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(lookup_and_update(in_item));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result hit=%0b read_value=%0d", out_item.hit, out_item.read_value);
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.hit !== exp_r.hit) begin
            $error("hit: expected %0b actual %0b", exp_r.hit, out_item.hit);
            failures++;
          end
          if (out_item.read_value !== exp_r.read_value) begin
            $error("read_value: expected %0d actual %0d", exp_r.read_value,
                   out_item.read_value);
            failures++;
          end
        end
      end
    end
  end

  function automatic lkvc_pkg::in_item_t make_item(logic cmd, logic [31:0] k,
                                                   logic [31:0] v);
    lkvc_pkg::in_item_t it;
    it.command = cmd;
    it.key = k;
    it.value = v;
    return it;
  endfunction

  // Keys drawn mostly from a small pool so hits and evictions both happen.
  function automatic lkvc_pkg::in_item_t random_item();
    logic [31:0] k;
    if ($urandom_range(9) == 0) k = $urandom();
    else k = key_pool[$urandom_range(5)];
    return make_item(1'($urandom_range(1)), k, $urandom());
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
    @(negedge clk);
    cfg_data  <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_cap = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [lkvc_pkg::CAP_W-1:0] caps [6];
    caps = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5};
    shadow_cap = lkvc_pkg::CAP_RESET;
    live_slots = 0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i] = '0;
      slot_data[i] = '0;
      slot_age[i] = 0;
    end
    for (int i = 0; i < 6; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme keys and values, get miss/hit, put update,
    // fill past capacity with reset capacity, then LRU eviction order.
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'h8000_0000, '0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, 32'h0, 32'h0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678));
    for (int i = 1; i <= 7; i++)
      pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, i, i * 3));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, '0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, '0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'h0, '0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'h1, '0));
    drain();

    // Lower capacity below the live count; inserts now replace in place.
    write_capacity(4'd2);
    for (int i = 10; i < 14; i++)
      pending_items.push_back(make_item(lkvc_pkg::CMD_PUT, i, i));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'd12, '0));
    pending_items.push_back(make_item(lkvc_pkg::CMD_GET, 32'd13, '0));
    drain();

    // Random phases over capacities and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 3) hold_go = 1'b1;
      for (int n = 0; n < 315; n++) pending_items.push_back(random_item());
      drain();
    end

    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
